FILE: src/maex_pkg.sv
// Shared types, opcode constants and helper functions for the integer execute block.
package maex_pkg;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
        logic [31:0] rd_value;
    } op_word_t;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  dest_index;
        logic [31:0] write_value;
        logic        unhandled;
    } res_word_t;

    typedef enum logic [1:0] {
        CLS_SIMPLE,
        CLS_MUL,
        CLS_DIV
    } op_class_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic mul_capture;
        logic acc_write;
        logic div_start;
        logic div_step;
        logic div_write;
        logic out_load;
    } maex_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        op_class_t cls;
        logic      div_last;
    } maex_sts_t;

    // Primary opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_SPECIAL3 = 6'd31;

    // SPECIAL function codes.
    localparam logic [5:0] FN_SLL   = 6'd0;
    localparam logic [5:0] FN_SRL   = 6'd2;
    localparam logic [5:0] FN_SRA   = 6'd3;
    localparam logic [5:0] FN_SLLV  = 6'd4;
    localparam logic [5:0] FN_SRLV  = 6'd6;
    localparam logic [5:0] FN_SRAV  = 6'd7;
    localparam logic [5:0] FN_MOVZ  = 6'd10;
    localparam logic [5:0] FN_MOVN  = 6'd11;
    localparam logic [5:0] FN_MFHI  = 6'd16;
    localparam logic [5:0] FN_MTHI  = 6'd17;
    localparam logic [5:0] FN_MFLO  = 6'd18;
    localparam logic [5:0] FN_MTLO  = 6'd19;
    localparam logic [5:0] FN_CLZ   = 6'd22;
    localparam logic [5:0] FN_CLO   = 6'd23;
    localparam logic [5:0] FN_MULT  = 6'd24;
    localparam logic [5:0] FN_MULTU = 6'd25;
    localparam logic [5:0] FN_DIV   = 6'd26;
    localparam logic [5:0] FN_DIVU  = 6'd27;
    localparam logic [5:0] FN_MADD  = 6'd28;
    localparam logic [5:0] FN_MADDU = 6'd29;
    localparam logic [5:0] FN_ADD   = 6'd32;
    localparam logic [5:0] FN_ADDU  = 6'd33;
    localparam logic [5:0] FN_SUB   = 6'd34;
    localparam logic [5:0] FN_SUBU  = 6'd35;
    localparam logic [5:0] FN_AND   = 6'd36;
    localparam logic [5:0] FN_OR    = 6'd37;
    localparam logic [5:0] FN_XOR   = 6'd38;
    localparam logic [5:0] FN_NOR   = 6'd39;
    localparam logic [5:0] FN_SLT   = 6'd42;
    localparam logic [5:0] FN_SLTU  = 6'd43;
    localparam logic [5:0] FN_MAX   = 6'd44;
    localparam logic [5:0] FN_MIN   = 6'd45;
    localparam logic [5:0] FN_MSUB  = 6'd46;
    localparam logic [5:0] FN_MSUBU = 6'd47;

    // SPECIAL3 function codes and BSHFL selectors.
    localparam logic [5:0] FN_EXT    = 6'd0;
    localparam logic [5:0] FN_INS    = 6'd4;
    localparam logic [5:0] FN_BSHFL  = 6'd32;
    localparam logic [4:0] SEL_WSBH  = 5'd2;
    localparam logic [4:0] SEL_WSBW  = 5'd3;
    localparam logic [4:0] SEL_SEB   = 5'd16;
    localparam logic [4:0] SEL_BITREV = 5'd20;
    localparam logic [4:0] SEL_SEH   = 5'd24;

    localparam logic [4:0] SEL_ROTATE = 5'd1;

    // Leading zero count by binary narrowing.
    function automatic logic [5:0] lead_zeros(input logic [31:0] v);
        logic [31:0] x;
        logic [5:0]  n;
        x = v;
        n = 6'd0;
        if (x == 32'd0) begin
            n = 6'd32;
        end
        else begin
            if (x[31:16] == 16'd0) begin n = n + 6'd16; x = x << 16; end
            if (x[31:24] == 8'd0)  begin n = n + 6'd8;  x = x << 8;  end
            if (x[31:28] == 4'd0)  begin n = n + 6'd4;  x = x << 4;  end
            if (x[31:30] == 2'd0)  begin n = n + 6'd2;  x = x << 2;  end
            if (x[31] == 1'b0)     begin n = n + 6'd1;               end
        end
        return n;
    endfunction

endpackage

FILE: src/maex_datapath.sv
// Operand registers, ALU result logic, multiplier, radix-2 divider and HI:LO.
module maex_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  maex_pkg::op_word_t op_data,
    input  maex_pkg::maex_cmd_t cmd,
    output maex_pkg::maex_sts_t sts,
    output maex_pkg::res_word_t res_data
);
    import maex_pkg::*;

    logic [31:0] instr_reg, rs_reg, rt_reg, rd_reg;
    logic [63:0] hilo_reg, hilo_next;
    logic [63:0] prod_reg;
    logic [31:0] quot_reg, rem_reg, dvsr_reg;
    logic [4:0]  cnt_reg;
    res_word_t   res_reg;

    logic [5:0]  op, fn;
    logic [4:0]  rsf, rtf, rdf, sa;
    logic [31:0] imm_sx, imm_zx;

    assign op     = instr_reg[31:26];
    assign rsf    = instr_reg[25:21];
    assign rtf    = instr_reg[20:16];
    assign rdf    = instr_reg[15:11];
    assign sa     = instr_reg[10:6];
    assign fn     = instr_reg[5:0];
    assign imm_zx = {16'd0, instr_reg[15:0]};
    assign imm_sx = {{16{instr_reg[15]}}, instr_reg[15:0]};

    // Classify the held instruction for the controller.
    always_comb begin
        sts.cls      = CLS_SIMPLE;
        sts.div_last = (cnt_reg == 5'd31);
        if (op == OP_SPECIAL) begin
            case (fn)
                FN_MULT, FN_MULTU, FN_MADD, FN_MADDU, FN_MSUB, FN_MSUBU: sts.cls = CLS_MUL;
                FN_DIV, FN_DIVU: sts.cls = CLS_DIV;
                default: sts.cls = CLS_SIMPLE;
            endcase
        end
    end

    // Signed forms use the odd-free function codes.
    logic is_signed;
    assign is_signed = (fn == FN_MULT) || (fn == FN_MADD) || (fn == FN_MSUB) || (fn == FN_DIV);

    // Register write result.
    logic [4:0]  shamt_v;
    logic [31:0] ones_mask, sm, val;
    logic [63:0] rot_src;
    logic        bad, wr;
    logic [4:0]  dst;

    always_comb begin
        shamt_v   = rs_reg[4:0];
        ones_mask = 32'hFFFF_FFFF >> (5'd31 - rdf);
        sm        = ones_mask >> sa;
        rot_src   = {rt_reg, rt_reg};
        bad       = 1'b0;
        wr        = 1'b1;
        dst       = rdf;
        val       = 32'd0;
        if (op == OP_SPECIAL) begin
            case (fn)
                FN_SLL:  val = rt_reg << sa;
                FN_SRL:  val = (rsf == SEL_ROTATE) ? 32'(rot_src >> sa) : (rt_reg >> sa);
                FN_SRA:  val = 32'($signed(rt_reg) >>> sa);
                FN_SLLV: val = rt_reg << shamt_v;
                FN_SRLV: val = (sa == SEL_ROTATE) ? 32'(rot_src >> shamt_v)
                                                  : (rt_reg >> shamt_v);
                FN_SRAV: val = 32'($signed(rt_reg) >>> shamt_v);
                FN_MOVZ: val = (rt_reg == 32'd0) ? rs_reg : rd_reg;
                FN_MOVN: val = (rt_reg != 32'd0) ? rs_reg : rd_reg;
                FN_MFHI: val = hilo_reg[63:32];
                FN_MFLO: val = hilo_reg[31:0];
                FN_MTHI, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
                FN_MADD, FN_MADDU, FN_MSUB, FN_MSUBU: wr = 1'b0;
                FN_CLZ:  val = {26'd0, lead_zeros(rs_reg)};
                FN_CLO:  val = {26'd0, lead_zeros(~rs_reg)};
                FN_ADD, FN_ADDU: val = rs_reg + rt_reg;
                FN_SUB, FN_SUBU: val = rs_reg - rt_reg;
                FN_AND:  val = rs_reg & rt_reg;
                FN_OR:   val = rs_reg | rt_reg;
                FN_XOR:  val = rs_reg ^ rt_reg;
                FN_NOR:  val = ~(rs_reg | rt_reg);
                FN_SLT:  val = {31'd0, $signed(rs_reg) < $signed(rt_reg)};
                FN_SLTU: val = {31'd0, rs_reg < rt_reg};
                FN_MAX:  val = ($signed(rs_reg) < $signed(rt_reg)) ? rt_reg : rs_reg;
                FN_MIN:  val = ($signed(rs_reg) < $signed(rt_reg)) ? rs_reg : rt_reg;
                default: bad = 1'b1;
            endcase
        end
        else if (op inside {[OP_ADDI:OP_LUI]}) begin
            dst = rtf;
            case (op)
                OP_ADDI, OP_ADDIU: val = rs_reg + imm_sx;
                OP_SLTI:  val = {31'd0, $signed(rs_reg) < $signed(imm_sx)};
                OP_SLTIU: val = {31'd0, rs_reg < imm_sx};
                OP_ANDI:  val = rs_reg & imm_zx;
                OP_ORI:   val = rs_reg | imm_zx;
                OP_XORI:  val = rs_reg ^ imm_zx;
                default:  val = {instr_reg[15:0], 16'd0};
            endcase
        end
        else if (op == OP_SPECIAL3) begin
            case (fn)
                FN_EXT: begin
                    dst = rtf;
                    val = (rs_reg >> sa) & ones_mask;
                end
                FN_INS: begin
                    dst = rtf;
                    val = (rt_reg & ~(sm << sa)) | ((rs_reg & sm) << sa);
                end
                FN_BSHFL: begin
                    case (sa)
                        SEL_SEB:    val = {{24{rt_reg[7]}}, rt_reg[7:0]};
                        SEL_SEH:    val = {{16{rt_reg[15]}}, rt_reg[15:0]};
                        SEL_BITREV: val = {<<{rt_reg}};
                        SEL_WSBH:   val = {rt_reg[23:16], rt_reg[31:24],
                                           rt_reg[7:0], rt_reg[15:8]};
                        SEL_WSBW:   val = {rt_reg[7:0], rt_reg[15:8],
                                           rt_reg[23:16], rt_reg[31:24]};
                        default:    bad = 1'b1;
                    endcase
                end
                default: bad = 1'b1;
            endcase
        end
        else begin
            bad = 1'b1;
        end
        if (bad || dst == 5'd0) begin
            wr = 1'b0;
        end
        if (!wr) begin
            dst = 5'd0;
            val = 32'd0;
        end
    end

    // Multiplier operands, sign- or zero-extended to 33 bits.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_a = {is_signed & rs_reg[31], rs_reg};
    assign mul_b = {is_signed & rt_reg[31], rt_reg};
    assign mul_p = mul_a * mul_b;

    // Divider: restoring, one quotient bit per step on magnitudes.
    logic        neg_a, neg_b;
    logic [31:0] mag_a, mag_b;
    logic [32:0] rem_sh, rem_diff;
    logic [31:0] q_fix, r_fix, q_out, r_out;
    assign neg_a    = is_signed & rs_reg[31];
    assign neg_b    = is_signed & rt_reg[31];
    assign mag_a    = neg_a ? (32'd0 - rs_reg) : rs_reg;
    assign mag_b    = neg_b ? (32'd0 - rt_reg) : rt_reg;
    assign rem_sh   = {rem_reg, quot_reg[31]};
    assign rem_diff = rem_sh - {1'b0, dvsr_reg};
    assign q_fix    = (neg_a ^ neg_b) ? (32'd0 - quot_reg) : quot_reg;
    assign r_fix    = neg_a ? (32'd0 - rem_reg) : rem_reg;

    always_comb begin
        q_out = q_fix;
        r_out = r_fix;
        if (rt_reg == 32'd0) begin
            r_out = rs_reg;
            if (is_signed) begin
                q_out = rs_reg[31] ? 32'd1 : 32'hFFFF_FFFF;
            end
            else begin
                q_out = (rs_reg > 32'h0000_FFFF) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
            end
        end
    end

    // HI:LO update.
    always_comb begin
        hilo_next = hilo_reg;
        if (cmd.acc_write) begin
            case (fn)
                FN_MADD, FN_MADDU: hilo_next = hilo_reg + prod_reg;
                FN_MSUB, FN_MSUBU: hilo_next = hilo_reg - prod_reg;
                default:           hilo_next = prod_reg;
            endcase
        end
        else if (cmd.div_write) begin
            hilo_next = {r_out, q_out};
        end
        else if (cmd.out_load && op == OP_SPECIAL && fn == FN_MTHI) begin
            hilo_next = {rs_reg, hilo_reg[31:0]};
        end
        else if (cmd.out_load && op == OP_SPECIAL && fn == FN_MTLO) begin
            hilo_next = {hilo_reg[63:32], rs_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hilo_reg <= 64'd0;
            cnt_reg  <= 5'd0;
        end
        else begin
            hilo_reg <= hilo_next;
            if (cmd.div_start) begin
                cnt_reg <= 5'd0;
            end
            else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            instr_reg <= op_data.instruction;
            rs_reg    <= op_data.rs_value;
            rt_reg    <= op_data.rt_value;
            rd_reg    <= op_data.rd_value;
        end
        if (cmd.mul_capture) begin
            prod_reg <= mul_p[63:0];
        end
        if (cmd.div_start) begin
            quot_reg <= mag_a;
            rem_reg  <= 32'd0;
            dvsr_reg <= mag_b;
        end
        else if (cmd.div_step) begin
            if (!rem_diff[32]) begin
                rem_reg  <= rem_diff[31:0];
                quot_reg <= {quot_reg[30:0], 1'b1};
            end
            else begin
                rem_reg  <= rem_sh[31:0];
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            res_reg.write_enable <= wr;
            res_reg.dest_index   <= dst;
            res_reg.write_value  <= val;
            res_reg.unhandled    <= bad;
        end
    end

    assign res_data = res_reg;

endmodule

FILE: src/maex_ctrl.sv
// Sequencing state machine for the integer execute block.
module maex_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_stall,
    output logic                res_valid,
    input  logic                res_stall,
    input  maex_pkg::maex_sts_t sts,
    output maex_pkg::maex_cmd_t cmd
);
    import maex_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ACC,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free, accept;

    assign out_free = !out_valid_reg || !res_stall;
    assign accept   = op_valid && (state_reg == S_IDLE);

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && res_stall;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (sts.cls)
                    CLS_MUL: begin
                        cmd.mul_capture = 1'b1;
                        state_next      = S_ACC;
                    end
                    CLS_DIV: begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    default: begin
                        if (out_free) begin
                            cmd.out_load   = 1'b1;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end
            S_ACC: begin
                cmd.acc_write = 1'b1;
                state_next    = S_FIN;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // Quotient is complete in S_FIN; commit HI:LO together with the result load.
        if (state_reg == S_FIN && sts.cls == CLS_DIV && out_free) begin
            cmd.div_write = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign op_stall  = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("operands loaded outside idle");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC || state_reg == S_FIN))
        else $error("result valid without a finishing step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !res_stall))
        else $error("result overwritten while stalled");

    a_div_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_write |-> cmd.out_load && sts.cls == CLS_DIV)
        else $error("divide commit apart from result load");

endmodule

FILE: src/mips_alu_muldiv_execute.sv
// Top level of the MIPS integer execute block with HI:LO multiply and divide.
//
//  channel | valid     | stall     | payload            | direction
//  --------+-----------+-----------+--------------------+----------
//  op      | op_valid  | op_stall  | op_data  (32x4)    | in
//  res     | res_valid | res_stall | res_data (1+5+32+1)| out
//
// One word at a time. ALU, HI/LO moves and unhandled codes finish in S_EXEC;
// multiply and multiply-accumulate pass S_ACC and S_FIN (multiply, then add
// into HI:LO), divide S_DIV and S_FIN (restoring, one quotient bit per cycle).
// rst_n clears the controller and HI:LO to zero; operand and result registers
// carry no reset. A stalled result stays in its output register while the next
// word is accepted; that word finishes only after the held result is taken.
module mips_alu_muldiv_execute (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_stall,
    input  maex_pkg::op_word_t  op_data,
    output logic                res_valid,
    input  logic                res_stall,
    output maex_pkg::res_word_t res_data
);
    import maex_pkg::*;

    maex_cmd_t cmd;
    maex_sts_t sts;

    // Sequence each word: load, execute, optional multiply or divide, deliver.
    maex_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold operands, compute the register write and maintain HI:LO.
    maex_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_data  (op_data),
        .cmd      (cmd),
        .sts      (sts),
        .res_data (res_data)
    );

endmodule
